@@ rtl/b64enc_pkg.sv @@
package b64enc_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [6:0] PAD_CHAR = 7'h3d;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
    logic       message_done;
  } out_beat_t;

  // three bytes, index of the last real character, flush marker
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  last_real;
    logic        flush;
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = 7'h00;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2b;
    end else begin
      c = 7'h2f;
    end
    return c;
  endfunction

endpackage

@@ rtl/b64enc_front.sv @@
module b64enc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  b64enc_pkg::in_beat_t byte_beat,
  input  logic               full,
  output logic               push,
  output b64enc_pkg::group_t push_group
);

  logic [1:0] byte_phase;
  logic [1:0] byte_phase_next;
  logic [7:0] held0;
  logic [7:0] held1;
  logic       accept;
  logic [1:0] ph;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;
  assign ph         = (byte_phase == 2'd3) ? 2'd2 : byte_phase;

  always_comb begin
    byte_phase_next = byte_phase;
    push            = 1'b0;
    push_group      = '0;
    if (accept) begin
      if (byte_beat.command == b64enc_pkg::CMD_DATA) begin
        if (ph < 2'd2) begin
          byte_phase_next = ph + 2'd1;
        end else begin
          push                 = 1'b1;
          push_group.bytes     = {held0, held1, byte_beat.data_byte};
          push_group.last_real = 2'd3;
          push_group.flush     = 1'b0;
          byte_phase_next      = 2'd0;
        end
      end else if (ph != 2'd0) begin
        push                 = 1'b1;
        push_group.bytes     = {held0, (ph == 2'd2) ? held1 : 8'h00, 8'h00};
        push_group.last_real = ph;
        push_group.flush     = 1'b1;
        byte_phase_next      = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= 2'd0;
    end else begin
      byte_phase <= byte_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_beat.command == b64enc_pkg::CMD_DATA) begin
      if (ph == 2'd0) begin
        held0 <= byte_beat.data_byte;
      end else if (ph == 2'd1) begin
        held1 <= byte_beat.data_byte;
      end
    end
  end

endmodule

@@ rtl/b64enc_fifo.sv @@
module b64enc_fifo #(
  parameter int unsigned Depth = b64enc_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64enc_pkg::group_t push_group,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output b64enc_pkg::group_t pop_group
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64enc_pkg::group_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign pop_group = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

endmodule

@@ rtl/b64enc_back.sv @@
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  b64enc_pkg::group_t    pop_group,
  output logic                  pop,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64enc_pkg::out_beat_t char_beat
);

  b64enc_pkg::group_t cur;
  logic               cur_valid;
  logic [1:0]         idx;
  logic               advance;
  logic [5:0]         sextet;
  logic [6:0]         ch;

  assign advance = cur_valid && (!char_valid || !char_stall);
  assign pop     = not_empty && (!cur_valid || (advance && idx == 2'd3));

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.bytes[23:18];
      2'd1:    sextet = cur.bytes[17:12];
      2'd2:    sextet = cur.bytes[11:6];
      2'd3:    sextet = cur.bytes[5:0];
      default: sextet = cur.bytes[5:0];
    endcase
    ch = (idx > cur.last_real) ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (advance) begin
        char_valid <= 1'b1;
        idx        <= idx + 2'd1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (advance && idx == 2'd3) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_group;
    end
    if (advance) begin
      char_beat.out_char     <= ch;
      char_beat.last_of_run  <= (idx == 2'd3);
      char_beat.message_done <= (idx == 2'd3) && cur.flush;
    end
  end

endmodule

@@ rtl/base64_stream_encoder.sv @@
// path: a third data byte, or an end beat with bytes held, goes through the queue
// and the current-group register to the char output register
// throughput: one char per cycle on the output register while char_stall is low,
// four chars per group of 3 bytes; input beats that complete no group are taken
// every cycle while the queue has room
// reset: rst is synchronous, active high; clears the byte phase, queue and char valid
module base64_stream_encoder #(
  parameter int unsigned FifoDepth = b64enc_pkg::FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  b64enc_pkg::in_beat_t  byte_beat,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64enc_pkg::out_beat_t char_beat
);

  logic               push;
  logic               full;
  logic               pop;
  logic               not_empty;
  b64enc_pkg::group_t push_group;
  b64enc_pkg::group_t pop_group;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .full       (full),
    .push       (push),
    .push_group (push_group)
  );

  b64enc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_group  (pop_group)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .pop_group  (pop_group),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat)
  );

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_beat.message_done) |-> char_beat.last_of_run)
    else $error("message done off a group boundary");

  assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_beat.out_char == b64enc_pkg::PAD_CHAR && !char_beat.last_of_run
     && !char_stall) |=> (char_valid && char_beat.out_char == b64enc_pkg::PAD_CHAR))
    else $error("pad not carried to end of group");

endmodule

@@ tb/sv/b64_char_checker.sv @@
module b64_char_checker
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_stall,
  input  in_beat_t  byte_beat,
  input  logic      char_valid,
  input  logic      char_stall,
  input  out_beat_t char_beat,
  output int        error_count,
  output int        chars_pending
);

  localparam logic [511:0] BASE64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [1:0] byte_phase;
  logic [7:0] held_bytes [2];
  out_beat_t  expected_chars [$];
  int         errors;

  initial begin
    errors        = 0;
    byte_phase    = 2'd0;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
  end

  function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
    logic [7:0] code;
    code = BASE64_ALPHABET[(63 - int'(sextet)) * 8 +: 8];
    return code[6:0];
  endfunction

  task automatic report_error(input string what);
    $display("error at %0t: %s", $realtime, what);
    errors++;
  endtask

  // queue the characters that one accepted byte beat causes
  task automatic encode_beat(input in_beat_t beat);
    logic [23:0] group_bits;
    out_beat_t   ch;
    int          k;
    if (beat.command == CMD_DATA) begin
      if (byte_phase < 2'd2) begin
        held_bytes[byte_phase] = beat.data_byte;
        byte_phase = byte_phase + 2'd1;
        return;
      end
      group_bits = {held_bytes[0], held_bytes[1], beat.data_byte};
      for (k = 0; k < 4; k++) begin
        ch.out_char     = alphabet_char(group_bits[23 - 6 * k -: 6]);
        ch.last_of_run  = (k == 3);
        ch.message_done = 1'b0;
        expected_chars.push_back(ch);
      end
      byte_phase = 2'd0;
    end else if (byte_phase != 2'd0) begin
      group_bits = {held_bytes[0], (byte_phase == 2'd2) ? held_bytes[1] : 8'h00, 8'h00};
      for (k = 0; k < 4; k++) begin
        ch.out_char     = (k <= int'(byte_phase)) ? alphabet_char(group_bits[23 - 6 * k -: 6])
                                                  : PAD_CHAR;
        ch.last_of_run  = (k == 3);
        ch.message_done = (k == 3);
        expected_chars.push_back(ch);
      end
      byte_phase = 2'd0;
    end
  endtask

  task automatic check_char(input out_beat_t got);
    out_beat_t want;
    if (expected_chars.size() == 0) begin
      report_error($sformatf("char %h arrived with none expected", got.out_char));
      return;
    end
    want = expected_chars.pop_front();
    if (got.out_char !== want.out_char)
      report_error($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
    if (got.last_of_run !== want.last_of_run)
      report_error($sformatf("last_of_run %b, expected %b", got.last_of_run,
                             want.last_of_run));
    if (got.message_done !== want.message_done)
      report_error($sformatf("message_done %b, expected %b", got.message_done,
                             want.message_done));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_phase = 2'd0;
      expected_chars.delete();
    end else begin
      if (byte_valid && !byte_stall) begin
        encode_beat(byte_beat);
      end
      if (char_valid && !char_stall) begin
        check_char(char_beat);
      end
    end
    chars_pending <= expected_chars.size();
    error_count   <= errors;
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top
  import b64enc_pkg::*;
;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 350;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_beat_t  byte_beat = '0;
  logic      char_valid;
  logic      char_stall = 1'b0;
  out_beat_t char_beat;

  int error_count;
  int chars_pending;
  int cycles = 0;
  int stall_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  always #1 clk = ~clk;

  base64_stream_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat)
  );

  b64_char_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_beat     (byte_beat),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_beat     (char_beat),
    .error_count   (error_count),
    .chars_pending (chars_pending)
  );

  // char side: after each accepted beat, stall for a random count
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
      stall_left = 0;
    end else if (char_valid && !char_stall) begin
      stall_left = rx_calm ? 0 : $urandom_range(0, 16);
      char_stall <= (stall_left > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      char_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] data);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= '{command: cmd, data_byte: data};
    do @(posedge clk); while (byte_stall);
  endtask

  task automatic drain_chars();
    byte_valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  initial begin : stimulus
    int  sent;
    int  len;
    bit  pressure_done;
    sent = 0;
    pressure_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hff);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_END,  8'ha5);
    send_beat(CMD_DATA, 8'hfb);
    send_beat(CMD_DATA, 8'hef);
    send_beat(CMD_DATA, 8'hbe);
    send_beat(CMD_DATA, 8'hff);
    send_beat(CMD_END,  8'hff);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hff);
    send_beat(CMD_END,  8'h5a);
    send_beat(CMD_END,  8'h00);
    send_beat(CMD_DATA, 8'h80);
    send_beat(CMD_DATA, 8'h01);
    send_beat(CMD_DATA, 8'h7f);
    send_beat(CMD_END,  8'h00);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_END,  8'h00);
    drain_chars();

    // random messages, with stray end beats and unterminated runs
    while (sent < RANDOM_BEATS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_beat(CMD_END, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
        repeat (len) begin
          send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
          sent++;
        end
        if ($urandom_range(0, 5) != 0) begin
          send_beat(CMD_END, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
      if (!pressure_done && sent >= RANDOM_BEATS / 2) begin
        drain_chars();
        pressure_done = 1'b1;
      end
    end
    send_beat(CMD_END, 8'h00);

    drain_chars();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_fifo.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
tb/sv/b64_char_checker.sv
tb/sv/tb_top.sv
